@@ hw/rtl/nmt_pkg.sv @@
// Shared types and constants for the NAT masquerade table.
// No dependencies; used by every module in hw/rtl.
`default_nettype none
package nmt_pkg;

  localparam int unsigned TableEntries = 32;
  localparam int unsigned TickBits     = 48;
  localparam int unsigned IdxBits      = $clog2(TableEntries);
  localparam int unsigned CntBits      = $clog2(TableEntries + 1);

  localparam logic [15:0] PortLowReset  = 16'd50000;
  localparam logic [15:0] PortHighReset = 16'd60000;
  localparam logic [31:0] LifetimeReset = 32'd12000;
  localparam logic [15:0] IpHeaderBytes = 16'd20;
  localparam logic [15:0] FragOffMask   = 16'h1FFF;
  localparam logic [15:0] IcmpMinL4     = 16'd8;
  localparam logic [15:0] PortsMinL4    = 16'd4;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [7:0] IcmpEchoReq   = 8'd8;
  localparam logic [7:0] IcmpEchoReply = 8'd0;

  // configuration register indexes
  localparam logic [2:0] RegNatEnabled = 3'd0;
  localparam logic [2:0] RegUplinkIp   = 3'd1;
  localparam logic [2:0] RegPortLow    = 3'd2;
  localparam logic [2:0] RegPortHigh   = 3'd3;
  localparam logic [2:0] RegLifetime   = 3'd4;

  localparam logic [1:0] VerdictXlate = 2'd0;
  localparam logic [1:0] VerdictDrop  = 2'd1;
  localparam logic [1:0] VerdictPass  = 2'd2;

  localparam logic CmdOutbound = 1'b0;
  localparam logic CmdInbound  = 1'b1;

  typedef struct packed {
    logic                command;
    logic [7:0]          namespace_id;
    logic [7:0]          protocol;
    logic [15:0]         frag_field;
    logic [15:0]         total_length;
    logic [31:0]         source_ip;
    logic [31:0]         dest_ip;
    logic [15:0]         l4_half0;
    logic [15:0]         l4_half1;
    logic [15:0]         l4_half2;
    logic [TickBits-1:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         verdict;
    logic [31:0]        new_source_ip;
    logic [31:0]        new_dest_ip;
    logic [15:0]        new_l4_half0;
    logic [15:0]        new_l4_half1;
    logic [15:0]        new_l4_half2;
    logic [31:0]        out_count;
    logic [31:0]        in_count;
    logic [31:0]        drop_count;
    logic [CntBits-1:0] active_maps;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_DROP,
    KIND_OUT,
    KIND_IN
  } kind_e;

  // classified item handed from front to back
  typedef struct packed {
    kind_e    kind;
    logic     icmp;
    logic [15:0] key_id;   // inner id outbound, outer id inbound
    logic [15:0] peer_id;  // peer id outbound
    in_item_t pkt;
  } work_t;

  typedef struct packed {
    logic        nat_enabled;
    logic [31:0] uplink_ip;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [31:0] lifetime;
    logic        cursor_load;
    logic [15:0] cursor_value;
  } cfg_t;

  // lowest set bit of a table-wide vector
  function automatic logic [IdxBits-1:0] first_set(input logic [TableEntries-1:0] v);
    logic [IdxBits-1:0] r;
    r = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (v[i]) r = IdxBits'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/nmt_front.sv @@
// Front end: configuration registers, packet classification and work queue.
// Depends on nmt_pkg.
`default_nettype none
module nmt_front import nmt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_data_i,
  output cfg_t          cfg_o,
  output logic          wq_valid_o,
  output work_t         wq_data_o,
  input  wire logic     wq_pop_i
);

  logic        nat_en_q;
  logic [31:0] uplink_q, life_q;
  logic [15:0] plow_q, phigh_q;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nat_en_q <= 1'b0;
      uplink_q <= '0;
      plow_q   <= PortLowReset;
      phigh_q  <= PortHighReset;
      life_q   <= LifetimeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegNatEnabled: nat_en_q <= cfg_data_i[0];
        RegUplinkIp:   uplink_q <= cfg_data_i;
        RegPortLow:    plow_q   <= cfg_data_i[15:0];
        RegPortHigh:   phigh_q  <= cfg_data_i[15:0];
        RegLifetime:   life_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.nat_enabled  = nat_en_q;
    cfg_o.uplink_ip    = uplink_q;
    cfg_o.port_low     = plow_q;
    cfg_o.port_high    = phigh_q;
    cfg_o.lifetime     = life_q;
    cfg_o.cursor_load  = cfg_we_i && (cfg_idx_i == RegPortLow);
    cfg_o.cursor_value = cfg_data_i[15:0];
  end

  // Classify the incoming packet
  work_t       cls;
  logic [15:0] l4len;
  logic        first_frag, ports_ok, icmp_ok;
  always_comb begin
    l4len      = in_data_i.total_length - IpHeaderBytes;
    first_frag = (in_data_i.frag_field & FragOffMask) == 16'd0;
    ports_ok   = ((in_data_i.protocol == ProtoTcp) || (in_data_i.protocol == ProtoUdp))
                 && (l4len >= PortsMinL4);
    icmp_ok    = (in_data_i.protocol == ProtoIcmp) && (l4len >= IcmpMinL4)
                 && ((in_data_i.l4_half0[15:8] == IcmpEchoReq)
                     || (in_data_i.l4_half0[15:8] == IcmpEchoReply));
    cls.pkt  = in_data_i;
    cls.icmp = icmp_ok;
    if (icmp_ok) begin
      cls.key_id  = in_data_i.l4_half2;
      cls.peer_id = in_data_i.l4_half2;
    end else if (in_data_i.command == CmdOutbound) begin
      cls.key_id  = in_data_i.l4_half0;
      cls.peer_id = in_data_i.l4_half1;
    end else begin
      cls.key_id  = in_data_i.l4_half1;
      cls.peer_id = in_data_i.l4_half1;
    end
    if (!nat_en_q || (in_data_i.total_length < IpHeaderBytes)) begin
      cls.kind = KIND_PASS;
    end else if (!first_frag || !(ports_ok || icmp_ok)) begin
      cls.kind = (in_data_i.command == CmdOutbound) ? KIND_DROP : KIND_PASS;
    end else begin
      cls.kind = (in_data_i.command == CmdOutbound) ? KIND_OUT : KIND_IN;
    end
  end

  // Two-entry work queue
  work_t      mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full       = cnt_q == 2'd2;
  assign wq_valid_o = cnt_q != 2'd0;
  assign wq_data_o  = mem[rd_q];
  assign do_push    = push && !full;
  assign do_pop     = wq_pop_i && wq_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/nmt_back.sv @@
// Back end: mapping table, ageing, lookup, port search and result register.
// Depends on nmt_pkg.
`default_nettype none
module nmt_back import nmt_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  wq_valid_i,
  input  wire work_t wq_data_i,
  output logic       wq_pop_o,
  output logic       empty,
  input  wire logic  pop,
  output out_item_t  out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_STALE, ST_MATCH, ST_PICK, ST_SEARCH, ST_UPDATE, ST_COUNT, ST_EMIT
  } state_e;

  // mapping table
  logic [TableEntries-1:0] valid_q;
  logic [7:0]          t_ns    [TableEntries];
  logic [7:0]          t_proto [TableEntries];
  logic [31:0]         t_iip   [TableEntries];
  logic [15:0]         t_iport [TableEntries];
  logic [15:0]         t_oport [TableEntries];
  logic [31:0]         t_pip   [TableEntries];
  logic [15:0]         t_pport [TableEntries];
  logic [TickBits-1:0] t_exp   [TableEntries];

  state_e              state_q;
  work_t               w_q;
  logic [TableEntries-1:0] hit_q, free_q;
  logic [IdxBits-1:0]  idx_q;
  logic [15:0]         tries_q, cursor_q;
  logic [1:0]          verdict_q;
  logic [31:0]         nsip_q, ndip_q, out_tot_q, in_tot_q, drop_tot_q;
  logic [15:0]         nh0_q, nh1_q, nh2_q;
  logic [CntBits-1:0]  active_q;
  logic                res_valid_q;
  out_item_t           res_q;

  // Parallel per-entry compares
  logic [TableEntries-1:0] stale_v, match_v, used_v;
  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      stale_v[i] = valid_q[i] && (w_q.pkt.now_tick >= t_exp[i]);
      used_v[i]  = valid_q[i] && (t_oport[i] == cursor_q);
      if (w_q.kind == KIND_OUT) begin
        match_v[i] = valid_q[i] && (t_ns[i] == w_q.pkt.namespace_id)
                     && (t_proto[i] == w_q.pkt.protocol)
                     && (t_iip[i] == w_q.pkt.source_ip) && (t_iport[i] == w_q.key_id)
                     && (t_pip[i] == w_q.pkt.dest_ip) && (t_pport[i] == w_q.peer_id);
      end else begin
        match_v[i] = valid_q[i] && (t_ns[i] == w_q.pkt.namespace_id)
                     && (t_proto[i] == w_q.pkt.protocol)
                     && (t_oport[i] == w_q.key_id) && (t_pip[i] == w_q.pkt.source_ip);
      end
    end
  end

  logic [15:0] cursor_next;
  always_comb begin
    cursor_next = cursor_q + 16'd1;
    if (cursor_next >= cfg_i.port_high) cursor_next = cfg_i.port_low;
  end

  logic search_hit, creating, emitting;
  assign search_hit = (state_q == ST_SEARCH) && (used_v == '0);
  assign creating   = search_hit;
  assign emitting   = (state_q == ST_EMIT) && (!res_valid_q || pop);
  assign wq_pop_o   = (state_q == ST_IDLE) && wq_valid_i;

  // Write entry fields on creation and expiry on use
  always_ff @(posedge clk_i) begin
    if (creating) begin
      t_ns[idx_q]    <= w_q.pkt.namespace_id;
      t_proto[idx_q] <= w_q.pkt.protocol;
      t_iip[idx_q]   <= w_q.pkt.source_ip;
      t_iport[idx_q] <= w_q.key_id;
      t_oport[idx_q] <= cursor_q;
      t_pip[idx_q]   <= w_q.pkt.dest_ip;
      t_pport[idx_q] <= w_q.peer_id;
    end
    if (state_q == ST_UPDATE) begin
      t_exp[idx_q] <= w_q.pkt.now_tick + TickBits'(cfg_i.lifetime);
    end
  end

  // Sequence one item through the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      cursor_q    <= PortLowReset;
      out_tot_q   <= '0;
      in_tot_q    <= '0;
      drop_tot_q  <= '0;
      active_q    <= '0;
      res_valid_q <= 1'b0;
      verdict_q   <= VerdictPass;
      tries_q     <= '0;
      idx_q       <= '0;
    end else begin
      if (pop && res_valid_q && !emitting) res_valid_q <= 1'b0;
      if (cfg_i.cursor_load) cursor_q <= cfg_i.cursor_value;
      else if (state_q == ST_SEARCH) cursor_q <= cursor_next;
      case (state_q)
        ST_IDLE: begin
          if (wq_valid_i) begin
            w_q    <= wq_data_i;
            nsip_q <= wq_data_i.pkt.source_ip;
            ndip_q <= wq_data_i.pkt.dest_ip;
            nh0_q  <= wq_data_i.pkt.l4_half0;
            nh1_q  <= wq_data_i.pkt.l4_half1;
            nh2_q  <= wq_data_i.pkt.l4_half2;
            case (wq_data_i.kind)
              KIND_PASS: begin
                verdict_q <= VerdictPass;
                state_q   <= ST_COUNT;
              end
              KIND_DROP: begin
                verdict_q  <= VerdictDrop;
                drop_tot_q <= drop_tot_q + 32'd1;
                state_q    <= ST_COUNT;
              end
              default: state_q <= ST_STALE;
            endcase
          end
        end
        ST_STALE: begin
          valid_q <= valid_q & ~stale_v;
          state_q <= ST_MATCH;
        end
        ST_MATCH: begin
          hit_q   <= match_v;
          free_q  <= ~valid_q;
          state_q <= ST_PICK;
        end
        ST_PICK: begin
          if (hit_q != '0) begin
            idx_q   <= first_set(hit_q);
            state_q <= ST_UPDATE;
          end else if (w_q.kind == KIND_IN) begin
            verdict_q <= VerdictPass;
            state_q   <= ST_COUNT;
          end else if ((free_q == '0) || (cfg_i.port_high <= cfg_i.port_low)) begin
            verdict_q  <= VerdictDrop;
            drop_tot_q <= drop_tot_q + 32'd1;
            state_q    <= ST_COUNT;
          end else begin
            idx_q   <= first_set(free_q);
            tries_q <= cfg_i.port_high - cfg_i.port_low;
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          tries_q  <= tries_q - 16'd1;
          if (search_hit) begin
            valid_q[idx_q] <= 1'b1;
            state_q        <= ST_UPDATE;
          end else if (tries_q == 16'd1) begin
            verdict_q  <= VerdictDrop;
            drop_tot_q <= drop_tot_q + 32'd1;
            state_q    <= ST_COUNT;
          end
        end
        ST_UPDATE: begin
          if (w_q.kind == KIND_IN) begin
            verdict_q <= VerdictXlate;
            in_tot_q  <= in_tot_q + 32'd1;
            ndip_q    <= t_iip[idx_q];
            if (w_q.icmp) nh2_q <= t_iport[idx_q];
            else          nh1_q <= t_iport[idx_q];
          end else if (cfg_i.uplink_ip != 32'd0) begin
            verdict_q <= VerdictXlate;
            out_tot_q <= out_tot_q + 32'd1;
            nsip_q    <= cfg_i.uplink_ip;
            if (w_q.icmp) nh2_q <= t_oport[idx_q];
            else          nh0_q <= t_oport[idx_q];
          end else begin
            verdict_q  <= VerdictDrop;
            drop_tot_q <= drop_tot_q + 32'd1;
          end
          state_q <= ST_COUNT;
        end
        ST_COUNT: begin
          active_q <= CntBits'($countones(valid_q));
          state_q  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emitting) begin
            res_q.verdict       <= verdict_q;
            res_q.new_source_ip <= nsip_q;
            res_q.new_dest_ip   <= ndip_q;
            res_q.new_l4_half0  <= nh0_q;
            res_q.new_l4_half1  <= nh1_q;
            res_q.new_l4_half2  <= nh2_q;
            res_q.out_count     <= out_tot_q;
            res_q.in_count      <= in_tot_q;
            res_q.drop_count    <= drop_tot_q;
            res_q.active_maps   <= active_q;
            res_valid_q         <= 1'b1;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign empty      = !res_valid_q;
  assign out_data_o = res_q;

endmodule
`default_nettype wire

@@ hw/rtl/nat_masquerade_table.sv @@
// Top level of the NAT masquerade table: joins front end and back end.
// Depends on nmt_pkg, nmt_front and nmt_back.
//
// Usage: packet headers enter through a queue-style port (push/full); the
// front end classifies each item and holds up to two in a work queue. The
// back end takes one item at a time and leaves its result in a one-entry
// result register read through empty/pop.
// Items that need no lookup (disabled, short, later fragment, untranslatable)
// pass from the work queue through the back-end states IDLE, COUNT and EMIT.
// A lookup adds STALE, MATCH and PICK, and UPDATE when a mapping is found or
// made; a new mapping is sought in SEARCH, one candidate pool port per cycle,
// which sets the worst case. The back end starts the next item only after
// the result of the last one has been written to the result register.
// Reset clears the table, the totals and the queues and loads the default
// registers; the block is ready in the first cycle after reset.
// A stalled receiver holds the result; the back end then waits with the
// next finished item, and full rises once the work queue holds two items.
// Configuration writes take effect at once; the user must make them only
// while idle, as the block itself does not enforce this.
`default_nettype none
module nat_masquerade_table import nmt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  in_data_i,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      out_data_o
);

  cfg_t  cfg;
  logic  wq_valid, wq_pop;
  work_t wq_data;

  nmt_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .in_data_i,
    .cfg_o      (cfg),
    .wq_valid_o (wq_valid),
    .wq_data_o  (wq_data),
    .wq_pop_i   (wq_pop)
  );

  nmt_back u_back (
    .clk_i, .rst_ni,
    .cfg_i      (cfg),
    .wq_valid_i (wq_valid),
    .wq_data_i  (wq_data),
    .wq_pop_o   (wq_pop),
    .empty, .pop, .out_data_o
  );

  // Results never report more mappings than the table holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.active_maps <= CntBits'(TableEntries)))
    else $error("active mapping count exceeds table size");

  // A waiting result holds while not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result changed while stalled");

  // Verdict code is one of the three defined values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.verdict != 2'd3))
    else $error("undefined verdict");

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for nat_masquerade_table: a directed table, then random
// header traffic, checked against a local model of the translation table.
// Depends on nmt_pkg and the nat_masquerade_table RTL only.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nmt_pkg::*;

  localparam int unsigned NumRandom = 900;
  localparam logic [TickBits-1:0] TickMax = '1;
  localparam int unsigned InBits = $bits(in_item_t);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = RegNatEnabled;
  logic [31:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_data_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_data_o;

  // verdict typed into the directed table, carried alongside the item
  logic        typed_on = 1'b0;
  logic [1:0]  typed_verdict = VerdictPass;

  nat_masquerade_table DUT (.*);

  always #4 clk_i = ~clk_i;

  // shadow registers and mapping table
  logic                nat_on;
  logic [31:0]         uplink;
  logic [15:0]         pool_lo, pool_hi, cursor;
  logic [31:0]         lifetime;
  logic [31:0]         tot_out, tot_in, tot_drop;
  logic                m_valid [TableEntries];
  logic [7:0]          m_ns [TableEntries];
  logic [7:0]          m_proto [TableEntries];
  logic [31:0]         m_inner_ip [TableEntries];
  logic [15:0]         m_inner_id [TableEntries];
  logic [15:0]         m_outer_id [TableEntries];
  logic [31:0]         m_peer_ip [TableEntries];
  logic [15:0]         m_peer_id [TableEntries];
  logic [TickBits-1:0] m_expiry [TableEntries];

  typedef struct packed {
    logic       on;
    logic [1:0] v;
  } typed_t;

  out_item_t   pending_results [$];
  typed_t      pending_typed [$];
  int unsigned err_cnt = 0;
  int unsigned accepted = 0;
  int unsigned results_seen = 0;
  int unsigned n_xlate = 0, n_drop = 0, n_pass = 0;
  logic [TickBits-1:0] now_q = '0;

  function automatic logic id_in_use(logic [15:0] p);
    for (int i = 0; i < TableEntries; i++)
      if (m_valid[i] && m_outer_id[i] == p) return 1'b1;
    return 1'b0;
  endfunction

  // allocate a slot and an outer id; -1 when the table or the pool is exhausted
  function automatic int alloc_mapping(logic [7:0] ns, logic [7:0] pr, logic [31:0] iip,
                                       logic [15:0] iid, logic [31:0] pip,
                                       logic [15:0] pid);
    int slot;
    int unsigned tries;
    logic [15:0] p;
    slot = -1;
    for (int i = 0; i < TableEntries; i++)
      if (!m_valid[i] && slot < 0) slot = i;
    if (slot < 0) return -1;
    tries = (pool_hi > pool_lo) ? pool_hi - pool_lo : 0;
    for (int unsigned t = 0; t < tries; t++) begin
      p = cursor;
      cursor = cursor + 16'd1;
      if (cursor >= pool_hi) cursor = pool_lo;
      if (!id_in_use(p)) begin
        m_valid[slot] = 1'b1;
        m_ns[slot] = ns;
        m_proto[slot] = pr;
        m_inner_ip[slot] = iip;
        m_inner_id[slot] = iid;
        m_outer_id[slot] = p;
        m_peer_ip[slot] = pip;
        m_peer_id[slot] = pid;
        m_expiry[slot] = '0;
        return slot;
      end
    end
    return -1;
  endfunction

  // work out the result of one header and update the shadow table
  function automatic out_item_t nat_translate(in_item_t p);
    out_item_t r;
    logic [15:0] h [3];
    logic [15:0] l4len;
    logic first, ok;
    int so, dof, m, cnt;
    logic [TickBits:0] sum;
    h[0] = p.l4_half0; h[1] = p.l4_half1; h[2] = p.l4_half2;
    r.verdict = VerdictPass;
    r.new_source_ip = p.source_ip;
    r.new_dest_ip = p.dest_ip;
    so = 0; dof = 1; ok = 1'b0; m = -1;
    if (nat_on && p.total_length >= IpHeaderBytes) begin
      l4len = p.total_length - IpHeaderBytes;
      first = (p.frag_field & FragOffMask) == 16'd0;
      if (p.protocol == ProtoTcp || p.protocol == ProtoUdp) begin
        ok = l4len >= PortsMinL4;
      end else if (p.protocol == ProtoIcmp) begin
        ok = l4len >= IcmpMinL4 &&
             (h[0][15:8] == IcmpEchoReq || h[0][15:8] == IcmpEchoReply);
        so = 2; dof = 2;
      end
      if (first && ok) begin
        // drop stale mappings before the lookup
        for (int i = 0; i < TableEntries; i++)
          if (m_valid[i] && p.now_tick >= m_expiry[i]) m_valid[i] = 1'b0;
      end
      if (p.command == CmdOutbound) begin
        r.verdict = VerdictDrop;
        if (first && ok) begin
          for (int i = 0; i < TableEntries; i++)
            if (m < 0 && m_valid[i] && m_ns[i] == p.namespace_id &&
                m_proto[i] == p.protocol && m_inner_ip[i] == p.source_ip &&
                m_inner_id[i] == h[so] && m_peer_ip[i] == p.dest_ip &&
                m_peer_id[i] == h[dof]) m = i;
          if (m < 0)
            m = alloc_mapping(p.namespace_id, p.protocol, p.source_ip, h[so],
                              p.dest_ip, h[dof]);
          if (m >= 0) begin
            sum = p.now_tick + lifetime;
            m_expiry[m] = sum[TickBits-1:0];
            if (uplink != 32'd0) begin
              r.new_source_ip = uplink;
              h[so] = m_outer_id[m];
              r.verdict = VerdictXlate;
              tot_out++;
            end
          end
        end
        if (r.verdict == VerdictDrop) tot_drop++;
      end else if (first && ok) begin
        for (int i = 0; i < TableEntries; i++)
          if (m < 0 && m_valid[i] && m_ns[i] == p.namespace_id &&
              m_proto[i] == p.protocol && m_outer_id[i] == h[dof] &&
              m_peer_ip[i] == p.source_ip) m = i;
        if (m >= 0) begin
          sum = p.now_tick + lifetime;
          m_expiry[m] = sum[TickBits-1:0];
          r.new_dest_ip = m_inner_ip[m];
          h[dof] = m_inner_id[m];
          r.verdict = VerdictXlate;
          tot_in++;
        end
      end
    end
    cnt = 0;
    for (int i = 0; i < TableEntries; i++) cnt += m_valid[i];
    r.new_l4_half0 = h[0];
    r.new_l4_half1 = h[1];
    r.new_l4_half2 = h[2];
    r.out_count = tot_out;
    r.in_count = tot_in;
    r.drop_count = tot_drop;
    r.active_maps = CntBits'(cnt);
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t header(logic cmd, logic [7:0] ns, logic [7:0] pr,
                                      logic [15:0] frag, logic [15:0] len,
                                      logic [31:0] sip, logic [31:0] dip,
                                      logic [15:0] h0, logic [15:0] h1,
                                      logic [15:0] h2);
    in_item_t p;
    p.command = cmd; p.namespace_id = ns; p.protocol = pr;
    p.frag_field = frag; p.total_length = len;
    p.source_ip = sip; p.dest_ip = dip;
    p.l4_half0 = h0; p.l4_half1 = h1; p.l4_half2 = h2;
    p.now_tick = now_q;
    return p;
  endfunction

  // one random header: mostly well-formed flows and replies, some noise
  function automatic in_item_t random_header();
    in_item_t p;
    int unsigned r;
    int e;
    logic [7:0] pr;
    now_q = now_q + $urandom_range(0, 12);
    r = $urandom_range(0, 99);
    if (r < 4) begin
      p = InBits'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      return p;
    end
    e = -1;
    if (r < 40) begin
      for (int k = 0; k < 4 && e < 0; k++) begin
        e = $urandom_range(0, TableEntries - 1);
        if (!m_valid[e]) e = -1;
      end
    end
    if (e >= 0) begin
      // reply to a live mapping
      if (m_proto[e] == ProtoIcmp)
        return header(CmdInbound, m_ns[e], ProtoIcmp, 16'h4000, 16'd84, m_peer_ip[e],
                      uplink, {IcmpEchoReply, 8'($urandom)}, 16'($urandom),
                      m_outer_id[e]);
      return header(CmdInbound, m_ns[e], m_proto[e], 16'h4000,
                    16'($urandom_range(24, 1500)), m_peer_ip[e], uplink,
                    m_peer_id[e], m_outer_id[e], 16'($urandom));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pr = ProtoTcp;
      4, 5, 6:    pr = ProtoUdp;
      7, 8:       pr = ProtoIcmp;
      default:    pr = 8'($urandom);
    endcase
    p = header($urandom_range(0, 99) < 80 ? CmdOutbound : CmdInbound,
               8'($urandom_range(0, 3)), pr,
               $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1)) << 14,
               $urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 30)) :
                                           16'($urandom_range(28, 1500)),
               {8'd10, 16'd0, 8'($urandom_range(1, 6))},
               {8'd93, 16'h1010, 8'($urandom_range(1, 4))},
               16'($urandom_range(40000, 40007)), 16'($urandom_range(80, 82)),
               16'($urandom_range(1, 5)));
    if (pr == ProtoIcmp)
      p.l4_half0 = {$urandom_range(0, 7) == 0 ? 8'($urandom) :
                    ($urandom_range(0, 1) ? IcmpEchoReq : IcmpEchoReply), 8'($urandom)};
    return p;
  endfunction

  // write one register and mirror it
  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegNatEnabled: nat_on = val[0];
      RegUplinkIp:   uplink = val;
      RegPortLow:    begin pool_lo = val[15:0]; cursor = val[15:0]; end
      RegPortHigh:   pool_hi = val[15:0];
      RegLifetime:   lifetime = val;
      default: ;
    endcase
  endtask

  task automatic set_all(logic en, logic [31:0] up, logic [15:0] lo, logic [15:0] hi,
                         logic [31:0] life);
    set_reg(RegNatEnabled, {31'd0, en});
    set_reg(RegUplinkIp, up);
    set_reg(RegPortLow, {16'd0, lo});
    set_reg(RegPortHigh, {16'd0, hi});
    set_reg(RegLifetime, life);
  endtask

  // offer one item after a random gap; return once it is accepted
  task automatic offer(in_item_t p, logic t_on, logic [1:0] t_v);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= p;
    typed_on <= t_on;
    typed_verdict <= t_v;
    do @(posedge clk_i); while (full);
  endtask

  // hold until every result is back, then give the block time to settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // record each accepted item and queue its expected result
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      pending_results.push_back(nat_translate(in_data_i));
      pending_typed.push_back({typed_on, typed_verdict});
      accepted++;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // compare each popped result with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t e;
    typed_t t;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", out_data_o);
        err_cnt++;
      end else begin
        e = pending_results.pop_front();
        t = pending_typed.pop_front();
        if (t.on) check_field("verdict (directed)", 32'(t.v), 32'(out_data_o.verdict));
        check_field("verdict", 32'(e.verdict), 32'(out_data_o.verdict));
        check_field("new_source_ip", e.new_source_ip, out_data_o.new_source_ip);
        check_field("new_dest_ip", e.new_dest_ip, out_data_o.new_dest_ip);
        check_field("new_l4_half0", 32'(e.new_l4_half0), 32'(out_data_o.new_l4_half0));
        check_field("new_l4_half1", 32'(e.new_l4_half1), 32'(out_data_o.new_l4_half1));
        check_field("new_l4_half2", 32'(e.new_l4_half2), 32'(out_data_o.new_l4_half2));
        check_field("out_count", e.out_count, out_data_o.out_count);
        check_field("in_count", e.in_count, out_data_o.in_count);
        check_field("drop_count", e.drop_count, out_data_o.drop_count);
        check_field("active_maps", 32'(e.active_maps), 32'(out_data_o.active_maps));
        case (e.verdict)
          VerdictXlate: n_xlate++;
          VerdictDrop:  n_drop++;
          default:      n_pass++;
        endcase
      end
    end
  end

  // receiver: random pop gaps, one long hold-off to fill the block
  initial begin
    int unsigned gap;
    bit held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      gap = idle_len();
      if (!held && accepted >= 200) begin
        held = 1;
        gap = 300;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  initial begin
    #30ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    in_item_t    d_items [$];
    typed_t      d_typed [$];
    int unsigned per_phase;
    for (int i = 0; i < TableEntries; i++) m_valid[i] = 1'b0;
    nat_on = 1'b0; uplink = '0; pool_lo = PortLowReset; pool_hi = PortHighReset;
    cursor = PortLowReset; lifetime = LifetimeReset;
    tot_out = '0; tot_in = '0; tot_drop = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // translation is off after reset
    offer(header(CmdOutbound, 8'd0, ProtoTcp, 16'd0, 16'd60, 32'h0A000001, 32'h5D101001,
                 16'd40000, 16'd80, 16'd0), 1'b1, VerdictPass);
    offer(header(CmdInbound, 8'd0, ProtoUdp, 16'd0, 16'd60, 32'h5D101001, 32'd0,
                 16'd53, 16'd50000, 16'd0), 1'b1, VerdictPass);
    drain();

    // directed table on a four-port pool
    set_all(1'b1, 32'hC0A80001, 16'd1000, 16'd1004, 32'd100);
    d_items = '{
      header(CmdOutbound, 8'd1, ProtoTcp, 16'd0, 16'd19, 32'h0A000001, 32'h5D101001,
             16'd40000, 16'd80, 16'd0),
      header(CmdOutbound, 8'd1, ProtoTcp, 16'h4000, 16'd24, 32'h0A000001, 32'h5D101001,
             16'd40000, 16'd80, 16'd0),
      header(CmdInbound, 8'd1, ProtoTcp, 16'h0000, 16'd40, 32'h5D101001, 32'hC0A80001,
             16'd80, 16'd1000, 16'd0),
      header(CmdOutbound, 8'd1, ProtoUdp, 16'h0001, 16'd40, 32'h0A000001, 32'h5D101001,
             16'd40001, 16'd53, 16'd0),
      header(CmdInbound, 8'd1, ProtoTcp, 16'h1FFF, 16'd40, 32'h5D101001, 32'hC0A80001,
             16'd80, 16'd1000, 16'd0),
      header(CmdOutbound, 8'd1, 8'd47, 16'd0, 16'd40, 32'h0A000001, 32'h5D101001,
             16'd0, 16'd0, 16'd0),
      header(CmdInbound, 8'd1, 8'd47, 16'd0, 16'd40, 32'h5D101001, 32'hC0A80001,
             16'd0, 16'd0, 16'd0),
      header(CmdOutbound, 8'd1, ProtoTcp, 16'd0, 16'd23, 32'h0A000001, 32'h5D101001,
             16'd40000, 16'd80, 16'd0),
      header(CmdOutbound, 8'd1, ProtoIcmp, 16'd0, 16'd28, 32'h0A000002, 32'h08080808,
             {IcmpEchoReq, 8'd0}, 16'hBEEF, 16'd7),
      header(CmdOutbound, 8'd1, ProtoIcmp, 16'd0, 16'd28, 32'h0A000002, 32'h08080808,
             16'h0300, 16'hBEEF, 16'd7),
      header(CmdOutbound, 8'd1, ProtoIcmp, 16'd0, 16'd27, 32'h0A000002, 32'h08080808,
             {IcmpEchoReq, 8'd0}, 16'hBEEF, 16'd7),
      header(CmdInbound, 8'd1, ProtoIcmp, 16'd0, 16'd28, 32'h08080808, 32'hC0A80001,
             {IcmpEchoReply, 8'd0}, 16'h1234, 16'd1001),
      header(CmdInbound, 8'd2, ProtoUdp, 16'd0, 16'd40, 32'h01020304, 32'hC0A80001,
             16'd53, 16'd1000, 16'd0),
      header(CmdOutbound, 8'd1, ProtoUdp, 16'd0, 16'd40, 32'h0A000003, 32'h5D101002,
             16'd1, 16'd2, 16'd0),
      header(CmdOutbound, 8'd1, ProtoUdp, 16'd0, 16'd40, 32'h0A000003, 32'h5D101002,
             16'd3, 16'd4, 16'd0),
      header(CmdOutbound, 8'd1, ProtoUdp, 16'd0, 16'd40, 32'h0A000003, 32'h5D101002,
             16'd5, 16'd6, 16'd0),
      header(CmdOutbound, 8'hFF, ProtoTcp, 16'hE000, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
             16'hFFFF, 16'hFFFF, 16'hFFFF),
      header(CmdInbound, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
             16'hFFFF, 16'hFFFF, 16'hFFFF)
    };
    d_typed = '{
      {1'b1, VerdictPass}, {1'b0, VerdictXlate}, {1'b0, VerdictXlate},
      {1'b1, VerdictDrop}, {1'b1, VerdictPass}, {1'b1, VerdictDrop},
      {1'b1, VerdictPass}, {1'b1, VerdictDrop}, {1'b0, VerdictXlate},
      {1'b1, VerdictDrop}, {1'b1, VerdictDrop}, {1'b0, VerdictXlate},
      {1'b1, VerdictPass}, {1'b0, VerdictXlate}, {1'b0, VerdictXlate},
      {1'b0, VerdictDrop}, {1'b0, VerdictXlate}, {1'b1, VerdictPass}
    };
    foreach (d_items[i]) offer(d_items[i], d_typed[i].on, d_typed[i].v);
    // past the lifetime: stale mappings clear and a new one fits
    now_q = now_q + 500;
    offer(header(CmdOutbound, 8'd1, ProtoUdp, 16'd0, 16'd40, 32'h0A000003, 32'h5D101002,
                 16'd5, 16'd6, 16'd0), 1'b0, VerdictXlate);
    typed_on <= 1'b0;
    drain();

    // random traffic over several register settings
    per_phase = NumRandom / 6;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_all(1'b1, $urandom | 32'd1, 16'd1000, 16'd1040, 32'd300);
        1: set_all(1'b1, 32'h0A0B0C0D, 16'd2000, 16'd2020, 32'd5000);
        2: set_all(1'b1, 32'd0, 16'd3000, 16'd3100, 32'd400);
        3: begin
          set_all(1'b1, 32'hFFFFFFFF, 16'd1, 16'd65535, 32'hFFFFFFFF);
          now_q = TickMax - 48'd3000;
        end
        4: set_all(1'b1, 32'h01010101, 16'd65535, 16'd2, 32'd1);
        default: begin
          set_all(1'b1, 32'hC6336401, PortLowReset, PortHighReset, LifetimeReset);
          now_q = 48'd5000;
        end
      endcase
      for (int unsigned k = 0; k < per_phase; k++) begin
        // one pause until the block has returned everything
        if (ph == 2 && k == per_phase / 2) begin
          push <= 1'b0;
          @(posedge clk_i);
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        // translation switched off for the tail of the last setting
        if (ph == 5 && k == per_phase - 40) begin
          drain();
          set_reg(RegNatEnabled, 32'd0);
        end
        offer(random_header(), 1'b0, VerdictPass);
      end
      drain();
    end

    $display("Checked %0d results: %0d translated, %0d dropped, %0d passed through,",
             results_seen, n_xlate, n_drop, n_pass);
    $display("over six pool and lifetime settings including tick wrap and empty pools.");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ nat_masquerade_table.f @@
hw/rtl/nmt_pkg.sv
hw/rtl/nmt_front.sv
hw/rtl/nmt_back.sv
hw/rtl/nat_masquerade_table.sv
dv/tb.sv
